// File: src/ffqlp_pkg.sv
// ----------------------------------------------------------------------------
// ffqlp_pkg
// shared types and constants of the fasta/fastq length parser
// ----------------------------------------------------------------------------
package ffqlp_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int TOTAL_BITS  = 48;
    localparam int COUNT_BITS  = 32;

    localparam int SEQ_OUT_W   = 32;
    localparam int TOTAL_OUT_W = 48;
    localparam int COUNT_OUT_W = 32;
    localparam int TDATA_W     = SEQ_OUT_W + TOTAL_OUT_W + COUNT_OUT_W;

    localparam int SUM_W = ((TOTAL_BITS > LENGTH_BITS) ? TOTAL_BITS : LENGTH_BITS) + 1;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
    localparam logic [TOTAL_BITS-1:0]  TOT_MAX = '1;
    localparam logic [COUNT_BITS-1:0]  CNT_MAX = '1;

    localparam int ADDR_W = 3;
    localparam logic [0:0] REG_FASTQ_MODE = 1'b0;

    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_FA_HEAD = 6'b000010,
        PH_FQ_HEAD = 6'b000100,
        PH_FQ_SEQ  = 6'b001000,
        PH_FQ_SEP  = 6'b010000,
        PH_FQ_QUAL = 6'b100000
    } phase_t;

    typedef struct packed {
        logic                   closed;
        logic [LENGTH_BITS-1:0] len;
        logic                   last;
    } event_t;

endpackage

// File: src/ffqlp_front.sv
// ----------------------------------------------------------------------------
// ffqlp_front
// byte parser: tracks the line phase and the open record length, and
// emits one event per closed record or end of stream
// ----------------------------------------------------------------------------
module ffqlp_front
    import ffqlp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fastq_mode,
    input  logic         in_valid,
    input  logic [7:0]   in_byte,
    input  logic         in_last,
    input  logic         q_full,
    output logic         in_ready,
    output logic         push,
    output event_t       push_event
);

    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] run_len_reg, run_len_next;
    logic [LENGTH_BITS-1:0] run_len_inc;
    logic                   accept;
    logic                   closed;
    logic [LENGTH_BITS-1:0] len;
    logic                   is_letter;
    logic                   is_nl;

    assign in_ready    = !q_full;
    assign accept      = in_valid && in_ready;
    assign run_len_inc = (run_len_reg == LEN_MAX) ? run_len_reg : run_len_reg + 1'b1;
    assign is_nl       = (in_byte == CH_NL);
    assign is_letter   = (in_byte inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]});

    always_comb
    begin
        phase_next   = phase_reg;
        run_len_next = run_len_reg;
        closed       = 1'b0;
        len          = '0;
        if (fastq_mode)
        begin
            case (phase_reg)
                PH_FQ_HEAD:
                begin
                    if (is_nl)
                    begin
                        run_len_next = '0;
                        phase_next   = PH_FQ_SEQ;
                    end
                end
                PH_FQ_SEQ:
                begin
                    if (is_nl)
                    begin
                        closed       = 1'b1;
                        len          = run_len_reg;
                        run_len_next = '0;
                        phase_next   = PH_FQ_SEP;
                    end
                    else
                    begin
                        run_len_next = run_len_inc;
                    end
                end
                PH_FQ_SEP:
                begin
                    if (is_nl)
                        phase_next = PH_FQ_QUAL;
                end
                PH_FQ_QUAL:
                begin
                    if (is_nl)
                        phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = (in_byte == CH_AT) ? PH_FQ_HEAD : PH_IDLE;
                end
            endcase
            if (in_last && !closed && (phase_next == PH_FQ_HEAD || phase_next == PH_FQ_SEQ))
            begin
                closed = 1'b1;
                len    = (phase_next == PH_FQ_SEQ) ? run_len_next : '0;
            end
        end
        else
        begin
            if (phase_reg == PH_FA_HEAD)
            begin
                if (is_nl)
                    phase_next = PH_IDLE;
            end
            else
            begin
                phase_next = PH_IDLE;
                if (in_byte == CH_GT)
                begin
                    if (run_len_reg != '0)
                    begin
                        closed       = 1'b1;
                        len          = run_len_reg;
                        run_len_next = '0;
                    end
                    phase_next = PH_FA_HEAD;
                end
                else if (is_letter)
                begin
                    run_len_next = run_len_inc;
                end
            end
            if (in_last && !closed && run_len_next != '0)
            begin
                closed = 1'b1;
                len    = run_len_next;
            end
        end
        if (in_last)
        begin
            phase_next   = PH_IDLE;
            run_len_next = '0;
        end
    end

    assign push              = accept && (closed || in_last);
    assign push_event.closed = closed;
    assign push_event.len    = len;
    assign push_event.last   = in_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            run_len_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            run_len_reg <= run_len_next;
        end
    end

endmodule

// File: src/ffqlp_queue.sv
// ----------------------------------------------------------------------------
// ffqlp_queue
// two-entry event queue between the parser and the accumulator
// ----------------------------------------------------------------------------
module ffqlp_queue
    import ffqlp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  event_t push_event,
    input  logic   pop,
    output logic   full,
    output logic   not_empty,
    output event_t head
);

    event_t     mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_event;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

// File: src/ffqlp_back.sv
// ----------------------------------------------------------------------------
// ffqlp_back
// accumulator: saturating base total and record count, output register
// ----------------------------------------------------------------------------
module ffqlp_back
    import ffqlp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  event_t             head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_length_valid,
    output logic [SEQ_OUT_W-1:0]   out_seq_length,
    output logic [TOTAL_OUT_W-1:0] out_total_bases,
    output logic [COUNT_OUT_W-1:0] out_record_count,
    output logic               out_stream_done
);

    logic [TOTAL_BITS-1:0]  total_reg, total_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]       sum;
    logic                   valid_reg;
    logic                   len_valid_reg;
    logic [SEQ_OUT_W-1:0]   seq_reg;
    logic [TOTAL_OUT_W-1:0] total_out_reg;
    logic [COUNT_OUT_W-1:0] count_out_reg;
    logic                   done_reg;

    assign pop = q_not_empty && (!valid_reg || out_ready);
    assign sum = SUM_W'(total_reg) + SUM_W'(head.len);

    always_comb
    begin
        total_next = total_reg;
        count_next = count_reg;
        if (head.closed)
        begin
            total_next = (sum > SUM_W'(TOT_MAX)) ? TOT_MAX : sum[TOTAL_BITS-1:0];
            count_next = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                valid_reg <= 1'b1;
                if (head.last)
                begin
                    total_reg <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    total_reg <= total_next;
                    count_reg <= count_next;
                end
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            len_valid_reg <= head.closed;
            seq_reg       <= head.closed ? SEQ_OUT_W'(head.len) : '0;
            total_out_reg <= TOTAL_OUT_W'(total_next);
            count_out_reg <= COUNT_OUT_W'(count_next);
            done_reg      <= head.last;
        end
    end

    assign out_valid        = valid_reg;
    assign out_length_valid = len_valid_reg;
    assign out_seq_length   = seq_reg;
    assign out_total_bases  = total_out_reg;
    assign out_record_count = count_out_reg;
    assign out_stream_done  = done_reg;

endmodule

// File: src/fasta_fastq_length_parser.sv
// ----------------------------------------------------------------------------
// fasta_fastq_length_parser
// sequence record length parser for fasta and fastq byte streams
// ----------------------------------------------------------------------------
// Takes one byte per cycle and reports each closed record's length with the
// running base total and record count; the item marked with s_tlast flushes
// any open record and yields a summary with m_tlast set, after which all
// totals restart from zero. The parser pushes an event into a two-entry queue
// when a record closes or the stream ends; the accumulator drains one event
// per cycle into the output register while the output is accepted, so the
// input sustains one byte per clock unless output stalls fill the queue.
// The user must write fastq_mode over the register port only while the
// stream is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module fasta_fastq_length_parser
    import ffqlp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // byte stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // data_byte
    input  logic               s_tlast,   // last
    // results
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // rec_length, total_bases, record_count
    output logic               m_tuser,   // length_valid
    output logic               m_tlast    // stream_done
);

    logic   fastq_mode_reg;
    logic   q_full;
    logic   q_not_empty;
    logic   push;
    logic   pop;
    event_t push_event;
    event_t head;

    logic [SEQ_OUT_W-1:0]   rec_length;
    logic [TOTAL_OUT_W-1:0] total_bases;
    logic [COUNT_OUT_W-1:0] record_count;

    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == REG_FASTQ_MODE) ? {31'b0, fastq_mode_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fastq_mode_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && paddr[2:2] == REG_FASTQ_MODE)
            fastq_mode_reg <= pwdata[0];
    end

    ffqlp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fastq_mode (fastq_mode_reg),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .q_full     (q_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_event (push_event)
    );

    ffqlp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_event (push_event),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    ffqlp_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_not_empty      (q_not_empty),
        .head             (head),
        .pop              (pop),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_length_valid (m_tuser),
        .out_seq_length   (rec_length),
        .out_total_bases  (total_bases),
        .out_record_count (record_count),
        .out_stream_done  (m_tlast)
    );

    assign m_tdata = {record_count, total_bases, rec_length};

endmodule
